>>> rtl/lsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared sizes, types and the three-bit line coding for the LED frame encoder.
// ----------------------------------------------------------------------------
package lsfe_pkg;

  // strip geometry
  localparam int unsigned STRIP_LEDS  = 64;
  localparam int unsigned RESET_BYTES = 16;

  localparam int unsigned LedIdxW  = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
  localparam int unsigned TailW    = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;
  // fill range arithmetic: start (6 bits) plus count (7 bits), and STRIP_LEDS itself
  localparam int unsigned FillW    = (STRIP_LEDS > 190) ? $clog2(STRIP_LEDS + 1) : 8;

  // byte position inside one led: three colors of three bytes
  localparam logic [3:0] SubLast   = 4'd8;

  // command codes on the input channel
  typedef enum logic {
    CMD_FILL = 1'b0,
    CMD_PULL = 1'b1
  } strip_cmd_e;

  typedef logic [23:0] pixel_t;

  // write port request into the pixel store
  typedef struct packed {
    logic               en;
    logic [LedIdxW-1:0] addr;
    pixel_t             data;
  } pix_wr_t;

  // each color bit b becomes the line bits 1 b 0, msb first
  function automatic logic [23:0] expand_color(input logic [7:0] c);
    logic [23:0] w;
    for (int k = 0; k < 8; k++) begin
      w[3*k+2] = 1'b1;
      w[3*k+1] = c[k];
      w[3*k]   = 1'b0;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lsfe_pixel_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_pixel_store
// One color per led in a synchronous memory with separate write and read
// ports, with per-entry valid flags: unwritten entries read zero after reset.
// ----------------------------------------------------------------------------
module lsfe_pixel_store import lsfe_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pix_wr_t            wr_i,
  input  wire logic [LedIdxW-1:0] rd_addr_i,
  output pixel_t                  rd_data_o
);

  pixel_t                mem [STRIP_LEDS];
  logic [STRIP_LEDS-1:0] valid_q;
  pixel_t                rd_data_q;
  logic                  rd_valid_q;

  // memory array, write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

>>> rtl/led_strip_spi_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_spi_frame_encoder_unit
// Led strip color store and three-bit spi frame serializer.
// ----------------------------------------------------------------------------
// Usage: the input channel takes command words. cmd 0 fills fill_count leds
// from start_led with one color (leds past the strip end are dropped) and
// rewinds the frame; it gives no output word. cmd 1 pulls the next spi byte
// of the frame: leds in green, red, blue order, msb first, each color bit as
// 110 or 100, nine bytes per led, then RESET_BYTES zero bytes, the last one
// flagged with frame_end. After that byte the frame starts over.
// A pull does a pixel memory read, then a byte format step that loads its
// byte into the output register. A fill writes one led per cycle after it
// is accepted; an empty fill writes nothing and leaves the block ready.
// One word is worked on at a time: the input is taken only while idle.
// Reset clears the stored colors (all leds black) and rewinds the frame.
// A stalled receiver holds the output word; further fills are still taken,
// and a pull waits in its format step until the output register frees up.
// ----------------------------------------------------------------------------
module led_strip_spi_frame_encoder_unit import lsfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       cmd_i,
  input  wire logic [5:0] start_led_i,
  input  wire logic [6:0] fill_count_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] line_byte_o,
  output logic            frame_end_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ
  } state_e;

  state_e             state_q;
  logic [FillW-1:0]   wr_idx_q;
  logic [FillW-1:0]   fill_end_q;
  pixel_t             color_q;
  logic [LedIdxW-1:0] led_q;
  logic [3:0]         sub_q;
  logic               tail_q;
  logic [TailW-1:0]   tail_cnt_q;
  logic               out_valid_q;
  logic [7:0]         line_byte_q;
  logic               frame_end_q;

  logic               in_acc;
  logic [FillW-1:0]   fill_sum;
  logic [FillW-1:0]   fill_end_d;
  logic [FillW-1:0]   start_ext;
  pix_wr_t            wr_req;
  pixel_t             pixel;
  logic [7:0]         color_sel;
  logic [1:0]         third;
  logic [23:0]        expanded;
  logic [7:0]         byte_d;
  logic               last_byte;
  logic               out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // clipped end of the fill range
  assign start_ext  = FillW'(start_led_i);
  assign fill_sum   = start_ext + FillW'(fill_count_i);
  assign fill_end_d = (fill_sum > FillW'(STRIP_LEDS)) ? FillW'(STRIP_LEDS) : fill_sum;

  // pixel store write during the fill sweep
  assign wr_req.en   = (state_q == ST_FILL);
  assign wr_req.addr = wr_idx_q[LedIdxW-1:0];
  assign wr_req.data = color_q;

  lsfe_pixel_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_req),
    .rd_addr_i(led_q),
    .rd_data_o(pixel)
  );

  // pick color and byte within the led
  always_comb begin
    color_sel = pixel[7:0];
    third     = 2'd0;
    unique case (sub_q)
      4'd0: begin color_sel = pixel[23:16]; third = 2'd0; end
      4'd1: begin color_sel = pixel[23:16]; third = 2'd1; end
      4'd2: begin color_sel = pixel[23:16]; third = 2'd2; end
      4'd3: begin color_sel = pixel[15:8];  third = 2'd0; end
      4'd4: begin color_sel = pixel[15:8];  third = 2'd1; end
      4'd5: begin color_sel = pixel[15:8];  third = 2'd2; end
      4'd6: begin color_sel = pixel[7:0];   third = 2'd0; end
      4'd7: begin color_sel = pixel[7:0];   third = 2'd1; end
      4'd8: begin color_sel = pixel[7:0];   third = 2'd2; end
      default: begin color_sel = pixel[7:0]; third = 2'd2; end
    endcase
  end

  assign expanded = expand_color(color_sel);

  always_comb begin
    unique case (third)
      2'd0:    byte_d = expanded[23:16];
      2'd1:    byte_d = expanded[15:8];
      default: byte_d = expanded[7:0];
    endcase
    if (tail_q) begin
      byte_d = 8'h00;
    end
  end

  assign last_byte = tail_q && (tail_cnt_q == TailW'(RESET_BYTES - 1));
  assign out_load  = (state_q == ST_READ) && (!out_valid_q || out_ready_i);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_i == CMD_FILL) begin
      color_q    <= {green_i, red_i, blue_i};
      fill_end_q <= fill_end_d;
    end
    if (out_load) begin
      line_byte_q <= byte_d;
      frame_end_q <= last_byte;
    end
  end

  // control: state, fill index, frame position, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      led_q       <= '0;
      sub_q       <= '0;
      tail_q      <= 1'b0;
      tail_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (cmd_i == CMD_FILL) begin
              led_q      <= '0;
              sub_q      <= '0;
              tail_q     <= 1'b0;
              tail_cnt_q <= '0;
              wr_idx_q   <= start_ext;
              if (start_ext < fill_end_d) begin
                state_q <= ST_FILL;
              end
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_FILL: begin
          if (wr_idx_q + FillW'(1) >= fill_end_q) begin
            state_q <= ST_IDLE;
          end
          wr_idx_q <= wr_idx_q + FillW'(1);
        end
        ST_READ: begin
          if (out_load) begin
            state_q <= ST_IDLE;
            if (tail_q) begin
              if (last_byte) begin
                tail_q     <= 1'b0;
                tail_cnt_q <= '0;
                led_q      <= '0;
                sub_q      <= '0;
              end else begin
                tail_cnt_q <= tail_cnt_q + TailW'(1);
              end
            end else if (sub_q == SubLast) begin
              sub_q <= '0;
              if (led_q == LedIdxW'(STRIP_LEDS - 1)) begin
                tail_q     <= 1'b1;
                tail_cnt_q <= '0;
              end else begin
                led_q <= led_q + LedIdxW'(1);
              end
            end else begin
              sub_q <= sub_q + 4'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_byte_o = line_byte_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

>>> rtl/lsfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_checker
// Port-level checks for the led frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lsfe_checker import lsfe_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       cmd_i,
  input wire logic [6:0] fill_count_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] line_byte_o,
  input wire logic       frame_end_o
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a pull occupies the block while it reads
  a_pull_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_PULL |=> !in_ready_o)
    else $error("pull accepted without memory read cycle");

  // a non-empty fill occupies the block while it writes
  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_FILL && fill_count_i != 7'd0
    |=> !in_ready_o)
    else $error("fill accepted without write sweep");

  // the flagged byte sits in the reset tail
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> line_byte_o == 8'h00)
    else $error("frame end flagged on a data byte");

endmodule

bind led_strip_spi_frame_encoder_unit lsfe_checker u_lsfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .fill_count_i(fill_count_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .line_byte_o (line_byte_o),
  .frame_end_o (frame_end_o)
);
`default_nettype wire
